// File: rtl/core/dzsp_pkg.sv
`default_nettype none

package dzsp_pkg;

  // Widths of the payload fields and of the configuration port.
  localparam int unsigned SampleW    = 24;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 5;
  localparam int unsigned JobBytes   = 4;
  localparam int unsigned JobCountW  = 3;
  localparam int unsigned QueueDepth = 2;

  // Default history depth.
  localparam int unsigned MaxChannelsDef = 16;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_VALUE_WIDTH   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_CHANNEL_COUNT = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_DELTA_ENABLE  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_ZIGZAG_ENABLE = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_DENSE_MODE    = 3'd4;

  // Register values after reset.
  localparam logic [4:0] VALUE_WIDTH_RST   = 5'd16;
  localparam logic [4:0] CHANNEL_COUNT_RST = 5'd4;

  typedef struct packed {
    logic [4:0] value_width;
    logic [4:0] channel_count;
    logic       delta_enable;
    logic       zigzag_enable;
    logic       dense_mode;
  } cfg_t;

  typedef struct packed {
    logic [SampleW-1:0] sample_value;
    logic               end_of_stream;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } out_req_t;

  // One sample's worth of bytes, least significant byte first.
  typedef struct packed {
    logic [8*JobBytes-1:0] data;
    logic [JobCountW-1:0]  count;
    logic                  last;
  } job_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic not_empty;
  } q_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/dzsp_front.sv
`default_nettype none

module dzsp_front #(
  parameter int unsigned MAX_CHANNELS = dzsp_pkg::MaxChannelsDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire dzsp_pkg::cfg_t   cfg_i,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire dzsp_pkg::in_req_t in_req_i,
  input  wire dzsp_pkg::q_stat_t q_stat_i,
  output logic                  push_o,
  output dzsp_pkg::job_t        job_o
);

  localparam int unsigned ChW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned CmpW = (ChW + 1 > 5) ? ChW + 1 : 5;
  localparam int unsigned SW   = dzsp_pkg::SampleW;

  logic              acc;
  logic              eos;
  logic [4:0]        w_eff;
  logic [4:0]        w_m1;
  logic [4:0]        w_sum;
  logic [SW-1:0]     mask;
  logic [SW-1:0]     cur;
  logic [SW-1:0]     hist;
  logic [SW-1:0]     diff;
  logic [SW-1:0]     val;
  logic              sign;
  logic [30:0]       dacc;
  logic [4:0]        dbits;
  logic [1:0]        nb;
  logic [2:0]        bc_after;
  logic [6:0]        accum_after;
  logic [31:0]       data;
  logic [2:0]        count;
  logic [CmpW-1:0]   nxt;
  logic [CmpW-1:0]   cc_ext;
  logic [CmpW-1:0]   eff_ch;

  logic [ChW-1:0]          chan_d, chan_q;
  logic [6:0]              accum_d, accum_q;
  logic [2:0]              bc_d, bc_q;
  logic [MAX_CHANNELS-1:0] hist_vld_d, hist_vld_q;
  logic [SW-1:0]           hist_rd_q;
  logic [SW-1:0]           hist_mem [MAX_CHANNELS];

  // A sample is taken whenever the queue has room.
  assign in_stall_o = q_stat_i.full;
  assign acc        = in_valid_i && !q_stat_i.full;
  assign eos        = in_req_i.end_of_stream;

  // Effective width and wrap mask.
  always_comb begin
    if (cfg_i.value_width == 5'd0) begin
      w_eff = 5'd1;
    end else if (cfg_i.value_width > 5'd24) begin
      w_eff = 5'd24;
    end else begin
      w_eff = cfg_i.value_width;
    end
  end
  assign w_m1 = w_eff - 5'd1;
  assign mask = ~({SW{1'b1}} << w_eff);
  assign cur  = in_req_i.sample_value & mask;

  // An entry that has not been written since the last clear reads as zero.
  assign hist = hist_vld_q[chan_q] ? hist_rd_q : '0;

  // Modulo difference and zigzag mapping.
  assign diff = (cur - hist) & mask;
  assign sign = diff[w_m1];
  always_comb begin
    val = cur;
    if (cfg_i.delta_enable) begin
      val = diff;
      if (cfg_i.zigzag_enable) begin
        // A negative difference maps to the complement of its double.
        val = ((diff << 1) ^ {SW{sign}}) & mask;
      end
    end
  end

  // Dense packing: merge with the pending bits and split off whole bytes.
  assign dacc  = ({7'd0, val} << bc_q) | {24'd0, accum_q};
  assign dbits = {2'b00, bc_q} + w_eff;
  assign w_sum = w_eff + 5'd7;
  always_comb begin
    case (dbits[4:3])
      2'd0:    accum_after = dacc[6:0];
      2'd1:    accum_after = dacc[14:8];
      2'd2:    accum_after = dacc[22:16];
      default: accum_after = dacc[30:24];
    endcase
  end

  // Byte list of this sample, including the flush byte at end of stream.
  always_comb begin
    if (cfg_i.dense_mode) begin
      nb       = dbits[4:3];
      bc_after = dbits[2:0];
      data     = {1'b0, dacc};
    end else begin
      nb       = w_sum[4:3];
      bc_after = bc_q;
      data     = {8'd0, val} | ({25'd0, accum_q} << {nb, 3'b000});
    end
    count = {1'b0, nb} + {2'b00, (eos && (bc_after != 3'd0))};
  end

  assign push_o      = acc && (count != 3'd0);
  assign job_o.data  = data;
  assign job_o.count = count;
  assign job_o.last  = eos;

  // Round-robin channel counter.
  assign cc_ext = CmpW'(cfg_i.channel_count);
  always_comb begin
    if (cfg_i.channel_count == 5'd0) begin
      eff_ch = CmpW'(1);
    end else if (cc_ext > CmpW'(MAX_CHANNELS)) begin
      eff_ch = CmpW'(MAX_CHANNELS);
    end else begin
      eff_ch = cc_ext;
    end
  end
  assign nxt = CmpW'(chan_q) + CmpW'(1);

  // Next values of the stream state.
  always_comb begin
    chan_d     = chan_q;
    accum_d    = accum_q;
    bc_d       = bc_q;
    hist_vld_d = hist_vld_q;
    if (acc) begin
      if (eos) begin
        chan_d     = '0;
        accum_d    = '0;
        bc_d       = '0;
        hist_vld_d = '0;
      end else begin
        chan_d             = (nxt >= eff_ch) ? '0 : nxt[ChW-1:0];
        hist_vld_d[chan_q] = 1'b1;
        if (cfg_i.dense_mode) begin
          accum_d = accum_after;
          bc_d    = bc_after;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q     <= '0;
      accum_q    <= '0;
      bc_q       <= '0;
      hist_vld_q <= '0;
    end else begin
      chan_q     <= chan_d;
      accum_q    <= accum_d;
      bc_q       <= bc_d;
      hist_vld_q <= hist_vld_d;
    end
  end

  // History memory: written at the current channel, read ahead at the next one.
  always_ff @(posedge clk_i) begin
    if (acc) begin
      hist_mem[chan_q] <= cur;
    end
    if (acc && (chan_d == chan_q)) begin
      hist_rd_q <= cur;
    end else begin
      hist_rd_q <= hist_mem[chan_d];
    end
  end

  // End of stream leaves the stream state cleared.
  a_eos_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && eos |=> (bc_q == 3'd0) && (chan_q == '0) && (hist_vld_q == '0))
    else $error("stream state not cleared after end of stream");

endmodule

`default_nettype wire

// File: rtl/core/dzsp_queue.sv
`default_nettype none

module dzsp_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire dzsp_pkg::job_t    job_i,
  input  wire logic              pop_i,
  output dzsp_pkg::job_t         head_o,
  output dzsp_pkg::q_stat_t      q_stat_o
);

  localparam int unsigned Depth = dzsp_pkg::QueueDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  dzsp_pkg::job_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_d, wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_d, rd_ptr_q;
  logic [CntW-1:0] cnt_d, cnt_q;

  assign head_o             = mem_q[rd_ptr_q];
  assign q_stat_o.full      = (cnt_q == CntW'(Depth));
  assign q_stat_o.not_empty = (cnt_q != '0);

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !q_stat_o.full)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> q_stat_o.not_empty)
    else $error("pop from an empty queue");

endmodule

`default_nettype wire

// File: rtl/core/dzsp_back.sv
`default_nettype none

module dzsp_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire dzsp_pkg::job_t    head_i,
  input  wire dzsp_pkg::q_stat_t q_stat_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output dzsp_pkg::out_req_t     out_req_o
);

  localparam int unsigned DataW = 8 * dzsp_pkg::JobBytes;
  localparam int unsigned CntW  = dzsp_pkg::JobCountW;

  logic                slot_free;
  logic [DataW-1:0]    cur_d, cur_q;
  logic [CntW-1:0]     rem_d, rem_q;
  logic                last_d, last_q;
  logic                out_vld_d, out_vld_q;
  dzsp_pkg::out_req_t  out_d, out_q;

  // The output register can take a new request when empty or being drained.
  assign slot_free = !out_vld_q || !out_stall_i;

  // Serialise the active job, then move on to the queue head.
  always_comb begin
    pop_o     = 1'b0;
    cur_d     = cur_q;
    rem_d     = rem_q;
    last_d    = last_q;
    out_vld_d = out_vld_q;
    out_d     = out_q;
    if (slot_free) begin
      if (rem_q != '0) begin
        out_vld_d       = 1'b1;
        out_d.out_byte  = cur_q[7:0];
        out_d.last_byte = last_q && (rem_q == CntW'(1));
        cur_d           = cur_q >> 8;
        rem_d           = rem_q - CntW'(1);
      end else if (q_stat_i.not_empty) begin
        pop_o           = 1'b1;
        out_vld_d       = 1'b1;
        out_d.out_byte  = head_i.data[7:0];
        out_d.last_byte = head_i.last && (head_i.count == CntW'(1));
        cur_d           = head_i.data >> 8;
        rem_d           = head_i.count - CntW'(1);
        last_d          = head_i.last;
      end else begin
        out_vld_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      rem_q     <= rem_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    last_q <= last_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_req_o   = out_q;

  a_job_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (head_i.count != '0) && (head_i.count <= CntW'(dzsp_pkg::JobBytes)))
    else $error("queued job has an invalid byte count");

endmodule

`default_nettype wire

// File: rtl/core/delta_zigzag_sample_packer_core.sv
`default_nettype none

// Channel   | Direction | Handshake                  | Payload
// ----------+-----------+----------------------------+------------------------------
// in        | input     | in_valid_i / in_stall_o    | in_req_i  (sample, end flag)
// out       | output    | out_valid_o / out_stall_i  | out_req_o (byte, last flag)
// cfg       | input     | cfg_we_i                   | cfg_idx_i, cfg_wdata_i
//
// The front takes one sample per cycle while the two-entry job queue has room.
// The back sends one byte per cycle while the output is not stalled. A sample
// makes 0 to 3 bytes, plus one at end of stream for the flush byte; a 24-bit
// stream makes 3 bytes per sample, so the byte-wide output sets the pace. The
// first byte passes through the job queue and then the output register.
// Reset clears the control state and history valid bits at once; there is no clearing pass.
// A stalled output fills the queue, after which in_stall_o rises.

module delta_zigzag_sample_packer_core #(
  parameter int unsigned MAX_CHANNELS = dzsp_pkg::MaxChannelsDef
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire dzsp_pkg::in_req_t                in_req_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output dzsp_pkg::out_req_t                    out_req_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [dzsp_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [dzsp_pkg::CfgDataW-1:0]    cfg_wdata_i
);

  dzsp_pkg::cfg_t    cfg_d, cfg_q;
  dzsp_pkg::job_t    job;
  dzsp_pkg::job_t    head;
  dzsp_pkg::q_stat_t q_stat;
  logic              push;
  logic              pop;

  // Configuration register decode.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dzsp_pkg::CFG_VALUE_WIDTH:   cfg_d.value_width   = cfg_wdata_i;
        dzsp_pkg::CFG_CHANNEL_COUNT: cfg_d.channel_count = cfg_wdata_i;
        dzsp_pkg::CFG_DELTA_ENABLE:  cfg_d.delta_enable  = cfg_wdata_i[0];
        dzsp_pkg::CFG_ZIGZAG_ENABLE: cfg_d.zigzag_enable = cfg_wdata_i[0];
        dzsp_pkg::CFG_DENSE_MODE:    cfg_d.dense_mode    = cfg_wdata_i[0];
        default:                     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.value_width   <= dzsp_pkg::VALUE_WIDTH_RST;
      cfg_q.channel_count <= dzsp_pkg::CHANNEL_COUNT_RST;
      cfg_q.delta_enable  <= 1'b0;
      cfg_q.zigzag_enable <= 1'b0;
      cfg_q.dense_mode    <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: transform and pack each sample into a job of bytes.
  dzsp_front #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .job_o      (job)
  );

  // Short job queue between front and back.
  dzsp_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .job_i    (job),
    .pop_i    (pop),
    .head_o   (head),
    .q_stat_o (q_stat)
  );

  // Back: one byte per cycle into the output register while the output is not stalled.
  dzsp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

endmodule

`default_nettype wire

// File: tb/dzsp_checker.sv
// Watches the request, result and register ports of the packer, predicts the
// byte stream from every accepted sample and compares it with what comes out.
module dzsp_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  input  wire logic                          in_stall_i,
  input  wire dzsp_pkg::in_req_t             in_req_i,
  input  wire logic                          out_valid_i,
  input  wire logic                          out_stall_i,
  input  wire dzsp_pkg::out_req_t            out_req_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [dzsp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [dzsp_pkg::CfgDataW-1:0] cfg_wdata_i,
  output int unsigned                        mismatch_count_o,
  output int unsigned                        bytes_due_o
);

  localparam int unsigned Chans = dzsp_pkg::MaxChannelsDef;

  // Own copy of the registers and of the stream state.
  dzsp_pkg::cfg_t     regs;
  logic [23:0]        chan_hist [Chans];
  logic [3:0]         chan_idx;
  logic [6:0]         pend_bits;
  logic [2:0]         pend_cnt;
  dzsp_pkg::out_req_t bytes_due [$];

  // Clears history, channel counter and the dense bit store.
  task automatic clear_stream();
    for (int i = 0; i < Chans; i++) begin
      chan_hist[i] = '0;
    end
    chan_idx  = '0;
    pend_bits = '0;
    pend_cnt  = '0;
  endtask

  // Works out the bytes that one accepted sample causes and queues them.
  task automatic pack_sample(input dzsp_pkg::in_req_t req);
    int unsigned        w;
    int unsigned        nch;
    int unsigned        bits;
    logic [31:0]        mask;
    logic [31:0]        cur;
    logic [31:0]        v;
    logic [31:0]        nxt;
    logic [63:0]        acc;
    dzsp_pkg::out_req_t step_q [$];
    dzsp_pkg::out_req_t item;

    w    = (regs.value_width == 0) ? 1 : (regs.value_width > 24) ? 24 : regs.value_width;
    nch  = (regs.channel_count == 0) ? 1 :
           (regs.channel_count > Chans) ? Chans : regs.channel_count;
    mask = (32'd1 << w) - 32'd1;
    cur  = {8'd0, req.sample_value} & mask;
    v    = cur;

    // Difference from the channel's previous sample, optionally zigzag-mapped.
    if (regs.delta_enable) begin
      v = (cur - {8'd0, chan_hist[chan_idx]}) & mask;
      if (regs.zigzag_enable) begin
        if (v[w-1]) begin
          v = ((((32'd1 << w) - v) << 1) - 32'd1) & mask;
        end else begin
          v = (v << 1) & mask;
        end
      end
    end

    // History and channel counter move on whether or not delta is in use.
    chan_hist[chan_idx] = cur[23:0];
    nxt = 32'(chan_idx) + 32'd1;
    chan_idx = (nxt >= nch) ? 4'd0 : nxt[3:0];

    item.last_byte = 1'b0;
    if (regs.dense_mode) begin
      acc  = {57'd0, pend_bits} | ({32'd0, v} << pend_cnt);
      bits = pend_cnt + w;
      while (bits >= 8) begin
        item.out_byte = acc[7:0];
        step_q.push_back(item);
        acc  = acc >> 8;
        bits = bits - 8;
      end
      pend_bits = acc[6:0];
      pend_cnt  = 3'(bits);
    end else begin
      for (int b = 0; b < (w + 7) / 8; b++) begin
        item.out_byte = v[7:0];
        step_q.push_back(item);
        v = v >> 8;
      end
    end

    // End of stream flushes the pending bits as one zero-padded byte.
    if (req.end_of_stream && pend_cnt != 0) begin
      item.out_byte = {1'b0, pend_bits};
      step_q.push_back(item);
    end

    foreach (step_q[k]) begin
      item = step_q[k];
      if (req.end_of_stream && k == step_q.size() - 1) begin
        item.last_byte = 1'b1;
      end
      bytes_due.push_back(item);
    end

    if (req.end_of_stream) begin
      clear_stream();
    end
  endtask

  // Compare results first, then track register writes and new requests.
  always @(posedge clk_i or negedge rst_ni) begin
    dzsp_pkg::out_req_t want;
    if (!rst_ni) begin
      regs.value_width   = dzsp_pkg::VALUE_WIDTH_RST;
      regs.channel_count = dzsp_pkg::CHANNEL_COUNT_RST;
      regs.delta_enable  = 1'b0;
      regs.zigzag_enable = 1'b0;
      regs.dense_mode    = 1'b1;
      clear_stream();
      bytes_due.delete();
      bytes_due_o      = 0;
      mismatch_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (bytes_due.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= 10) begin
            $display("%0t: unexpected byte %h last %b", $realtime,
                     out_req_i.out_byte, out_req_i.last_byte);
          end
        end else begin
          want = bytes_due.pop_front();
          if (out_req_i.out_byte !== want.out_byte ||
              out_req_i.last_byte !== want.last_byte) begin
            mismatch_count_o++;
            if (mismatch_count_o <= 10) begin
              $display("%0t: byte expected %h got %h, last expected %b got %b",
                       $realtime, want.out_byte, out_req_i.out_byte,
                       want.last_byte, out_req_i.last_byte);
            end
          end
        end
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          dzsp_pkg::CFG_VALUE_WIDTH:   regs.value_width   = cfg_wdata_i;
          dzsp_pkg::CFG_CHANNEL_COUNT: regs.channel_count = cfg_wdata_i;
          dzsp_pkg::CFG_DELTA_ENABLE:  regs.delta_enable  = cfg_wdata_i[0];
          dzsp_pkg::CFG_ZIGZAG_ENABLE: regs.zigzag_enable = cfg_wdata_i[0];
          dzsp_pkg::CFG_DENSE_MODE:    regs.dense_mode    = cfg_wdata_i[0];
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_i) begin
        pack_sample(in_req_i);
      end
      bytes_due_o = bytes_due.size();
    end
  end

endmodule

// File: tb/tb.sv
module tb;

  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          in_valid  = 1'b0;
  logic                          in_stall;
  dzsp_pkg::in_req_t             in_req    = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  dzsp_pkg::out_req_t            out_req;
  logic                          cfg_we    = 1'b0;
  logic [dzsp_pkg::CfgIdxW-1:0]  cfg_idx   = '0;
  logic [dzsp_pkg::CfgDataW-1:0] cfg_wdata = '0;
  int unsigned                   mismatches;
  int unsigned                   bytes_due;
  int unsigned                   in_idle_pct   = 0;
  int unsigned                   out_stall_pct = 0;
  logic [23:0]                   prev_sample   = '0;

  delta_zigzag_sample_packer_core i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_req_o   (out_req),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  dzsp_checker i_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_req_i         (in_req),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_req_i        (out_req),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .mismatch_count_o (mismatches),
    .bytes_due_o      (bytes_due)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2000000;
    $display("delta_zigzag_sample_packer_core test failed");
    $finish;
  end

  // The receiver stalls at random, at the rate of the current phase.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  // Leaves the write enable high; the caller lowers it after the last write.
  task automatic write_reg(input logic [dzsp_pkg::CfgIdxW-1:0] idx,
                           input logic [dzsp_pkg::CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk);
  endtask

  task automatic close_cfg();
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_cfg(input logic [4:0] width, input logic [4:0] chans,
                         input logic [4:0] delta, input logic [4:0] zigzag,
                         input logic [4:0] dense);
    write_reg(dzsp_pkg::CFG_VALUE_WIDTH, width);
    write_reg(dzsp_pkg::CFG_CHANNEL_COUNT, chans);
    write_reg(dzsp_pkg::CFG_DELTA_ENABLE, delta);
    write_reg(dzsp_pkg::CFG_ZIGZAG_ENABLE, zigzag);
    write_reg(dzsp_pkg::CFG_DENSE_MODE, dense);
    close_cfg();
  endtask

  // Offers one request after a random idle stretch and waits for it to go in.
  task automatic send_sample(input logic [23:0] sample, input logic eos);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= '{sample_value: sample, end_of_stream: eos};
    prev_sample = sample;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Waits until every predicted byte has come out and the block has gone quiet.
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (bytes_due != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  // A run of samples: mostly small steps and random values, some extremes.
  task automatic run_stream(input int unsigned count, input int unsigned eos_pct,
                            input logic end_with_eos);
    logic [23:0] sample;
    logic        eos;
    for (int unsigned n = 0; n < count; n++) begin
      case ($urandom_range(3))
        0:       sample = prev_sample + 24'($urandom_range(15)) - 24'd8;
        1:       sample = $urandom_range(1) ? 24'hFFFFFF : 24'h000000;
        default: sample = 24'($urandom);
      endcase
      eos = ($urandom_range(99) < eos_pct) || (end_with_eos && n == count - 1);
      send_sample(sample, eos);
    end
  endtask

  task automatic set_mode(input int unsigned mode);
    case (mode)
      0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
      1: begin in_idle_pct = 80; out_stall_pct = 0;  end
      2: begin in_idle_pct = 0;  out_stall_pct = 80; end
      default: begin in_idle_pct = 24; out_stall_pct = 24; end
    endcase
  endtask

  initial begin
    logic [4:0] width;
    logic [4:0] chans;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Values after reset: 16-bit dense, four channels.
    send_sample(24'hFFFFFF, 1'b0);
    send_sample(24'h000000, 1'b0);
    send_sample(24'h123456, 1'b0);
    send_sample(24'hABCDEF, 1'b1);
    settle();

    // Width and channel count of zero, one-bit data with upper bits set, and
    // writes to indexes beyond the register list, which must change nothing.
    write_reg(dzsp_pkg::CFG_VALUE_WIDTH, 5'd0);
    write_reg(dzsp_pkg::CFG_CHANNEL_COUNT, 5'd0);
    write_reg(dzsp_pkg::CFG_DELTA_ENABLE, 5'b00001);
    write_reg(dzsp_pkg::CFG_ZIGZAG_ENABLE, 5'b11111);
    write_reg(dzsp_pkg::CFG_DENSE_MODE, 5'b10101);
    write_reg(dzsp_pkg::CFG_DENSE_MODE + 3'd1, 5'h1F);
    write_reg(dzsp_pkg::CFG_DENSE_MODE + 3'd2, 5'h1F);
    write_reg(dzsp_pkg::CFG_DENSE_MODE + 3'd3, 5'h1F);
    close_cfg();
    send_sample(24'h000001, 1'b0);
    send_sample(24'h000000, 1'b0);
    send_sample(24'hFFFFFE, 1'b0);
    send_sample(24'h000001, 1'b0);
    send_sample(24'h000001, 1'b0);
    send_sample(24'h000000, 1'b0);
    send_sample(24'h000001, 1'b1);
    settle();

    // Oversized width and channel count, aligned bytes, zigzag at the extremes.
    set_cfg(5'd31, 5'd31, 5'd1, 5'd1, 5'b11110);
    send_sample(24'h000000, 1'b0);
    send_sample(24'hFFFFFF, 1'b0);
    send_sample(24'h800000, 1'b0);
    send_sample(24'h7FFFFF, 1'b0);
    send_sample(24'h000001, 1'b1);
    settle();

    // Leave dense bits pending and the channel counter high, then lower the
    // channel count and switch to aligned bytes before the stream ends.
    set_cfg(5'd5, 5'd8, 5'd0, 5'd0, 5'd1);
    run_stream(7, 0, 1'b0);
    settle();
    set_cfg(5'd12, 5'd2, 5'd1, 5'd0, 5'd0);
    send_sample(24'($urandom), 1'b0);
    send_sample(24'($urandom), 1'b1);
    settle();

    // Random streams over fixed and random settings and every idling pattern.
    for (int unsigned k = 0; k < 8; k++) begin
      set_mode(k % 4);
      if (k == 0) begin
        set_cfg(5'd24, 5'd16, 5'd1, 5'd1, 5'd1);
      end else if (k == 1) begin
        set_cfg(5'd1, 5'd1, 5'd1, 5'd0, 5'd0);
      end else begin
        width = ($urandom_range(7) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(1, 24));
        chans = ($urandom_range(7) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(1, 16));
        set_cfg(width, chans, 5'($urandom), 5'($urandom), 5'($urandom));
      end
      run_stream(12, 10, $urandom_range(3) != 0);
      settle();
    end

    if (mismatches == 0 && bytes_due == 0) begin
      $display("delta_zigzag_sample_packer_core test passed");
    end else begin
      $display("delta_zigzag_sample_packer_core test failed");
    end
    $finish;
  end

endmodule
